@@ src/sqse_pkg.sv @@
// shared types and constants for the stack/queue swap engine
// no dependencies; used by sqse_ctrl, sqse_datapath and stack_queue_swap_engine
package sqse_pkg;

    localparam int DEPTH_DEFAULT = 8;

    localparam logic [2:0] OP_PUSH    = 3'd0;
    localparam logic [2:0] OP_POP     = 3'd1;
    localparam logic [2:0] OP_ENQUEUE = 3'd2;
    localparam logic [2:0] OP_DEQUEUE = 3'd3;
    localparam logic [2:0] OP_SWAP    = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic signed [31:0] EMPTY_WORD = -32'sd100;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWAP_RD,
        S_SWAP_WR
    } state_t;

    // swap runs in three passes
    typedef enum logic [1:0] {
        PH_SAVE_QUEUE,
        PH_LOAD_QUEUE,
        PH_LOAD_STACK
    } phase_t;

    typedef enum logic [1:0] {
        SRC_REG,
        SRC_STACK,
        SRC_QUEUE
    } src_t;

    typedef struct packed {
        logic   issue;
        logic   swap_init;
        logic   sw_rd;
        logic   sw_wr;
        logic   sw_clr;
        logic   sw_done;
        phase_t phase;
    } cmd_t;

    typedef struct packed {
        logic ph_empty;
        logic ph_last;
    } dp_stat_t;

endpackage

@@ src/stack_queue_swap_engine.sv @@
// top level of the stack/queue swap engine: controller plus datapath
// depends on sqse_pkg, sqse_ctrl and sqse_datapath
//
// A LIFO stack and a circular FIFO queue of DEPTH signed words. A request is taken when
// start is high and busy is low; its result (value_out, status) shows for exactly one cycle
// with done high and cannot be held off. Push, pop, enqueue and dequeue answer in the cycle
// after the request and leave busy low, so one request can be taken every cycle.
// A swap holds busy high while it copies through the memories' single read and write port,
// one word at a time, read in S_SWAP_RD and written in S_SWAP_WR: the queue into the swap
// buffer, the stack into the queue, then the buffer into the stack. Its result shows in the
// cycle busy falls.
module stack_queue_swap_engine #(
    parameter int DEPTH = sqse_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         op,
    input  logic signed [31:0] value_in,
    output logic               done,
    output logic signed [31:0] value_out,
    output logic [1:0]         status
);

    sqse_pkg::cmd_t     cmd;
    sqse_pkg::dp_stat_t stat;

    sqse_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    sqse_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .op        (op),
        .value_in  (value_in),
        .stat      (stat),
        .done      (done),
        .value_out (value_out),
        .status    (status)
    );

    // every request other than a swap answers on the next cycle
    a_single_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op != sqse_pkg::OP_SWAP) |=> done)
        else $error("request without result on the following cycle");

    // busy only ever rises because a swap was taken
    a_busy_from_swap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && op == sqse_pkg::OP_SWAP))
        else $error("busy raised without a swap request");

    // a swap ends with its result
    a_swap_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (done && status == sqse_pkg::ST_OK && value_out == '0))
        else $error("swap finished without an ok result");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == sqse_pkg::ST_EMPTY) |-> (value_out == sqse_pkg::EMPTY_WORD))
        else $error("empty status with wrong read word");

endmodule

@@ src/sqse_ctrl.sv @@
// controller state machine: sequences single operations and the swap passes
// depends on sqse_pkg
module sqse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        op,
    input  sqse_pkg::dp_stat_t stat,
    output sqse_pkg::cmd_t    cmd,
    output logic              busy
);

    sqse_pkg::state_t state_reg, state_next;
    sqse_pkg::phase_t phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sqse_pkg::S_IDLE;
            phase_reg <= sqse_pkg::PH_SAVE_QUEUE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        logic advance;
        advance    = 1'b0;
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.phase  = phase_reg;
        busy       = (state_reg != sqse_pkg::S_IDLE);

        unique case (state_reg)
            sqse_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (op == sqse_pkg::OP_SWAP)
                    begin
                        cmd.swap_init = 1'b1;
                        phase_next    = sqse_pkg::PH_SAVE_QUEUE;
                        state_next    = sqse_pkg::S_SWAP_RD;
                    end
                    else
                    begin
                        cmd.issue = 1'b1;
                    end
                end
            end
            sqse_pkg::S_SWAP_RD:
            begin
                if (stat.ph_empty)
                begin
                    advance = 1'b1;
                end
                else
                begin
                    cmd.sw_rd  = 1'b1;
                    state_next = sqse_pkg::S_SWAP_WR;
                end
            end
            sqse_pkg::S_SWAP_WR:
            begin
                cmd.sw_wr = 1'b1;
                if (stat.ph_last)
                begin
                    advance = 1'b1;
                end
                else
                begin
                    state_next = sqse_pkg::S_SWAP_RD;
                end
            end
            default:
            begin
                state_next = sqse_pkg::S_IDLE;
            end
        endcase

        // move on to the next pass, or close the swap after the last one
        if (advance)
        begin
            cmd.sw_clr = 1'b1;
            unique case (phase_reg)
                sqse_pkg::PH_SAVE_QUEUE:
                begin
                    phase_next = sqse_pkg::PH_LOAD_QUEUE;
                    state_next = sqse_pkg::S_SWAP_RD;
                end
                sqse_pkg::PH_LOAD_QUEUE:
                begin
                    phase_next = sqse_pkg::PH_LOAD_STACK;
                    state_next = sqse_pkg::S_SWAP_RD;
                end
                default:
                begin
                    cmd.sw_done = 1'b1;
                    state_next  = sqse_pkg::S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/sqse_datapath.sv @@
// datapath: stack, queue and swap buffer memories, fill counters, result register
// depends on sqse_pkg; driven by sqse_ctrl commands
module sqse_datapath #(
    parameter int DEPTH = sqse_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sqse_pkg::cmd_t      cmd,
    input  logic [2:0]          op,
    input  logic signed [31:0]  value_in,
    output sqse_pkg::dp_stat_t  stat,
    output logic                done,
    output logic signed [31:0]  value_out,
    output logic [1:0]          status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    logic signed [31:0] stack_mem [DEPTH];
    logic signed [31:0] queue_mem [DEPTH];
    logic signed [31:0] buf_mem   [DEPTH];

    logic signed [31:0] stack_rdata_reg, queue_rdata_reg, buf_rdata_reg;

    logic [CW-1:0] stack_count_reg, stack_count_next;
    logic [CW-1:0] queue_count_reg, queue_count_next;
    logic [AW-1:0] queue_head_reg, queue_head_next;
    logic [AW-1:0] queue_tail_reg, queue_tail_next;
    logic [CW-1:0] qn_reg, qn_next;
    logic [CW-1:0] sn_reg, sn_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] slot_reg, slot_next;

    logic               done_reg, done_next;
    logic [1:0]         status_reg, status_next;
    logic signed [31:0] val_reg, val_next;
    sqse_pkg::src_t     src_reg, src_next;

    logic               stk_we, stk_re, que_we, que_re, buf_we, buf_re;
    logic [AW-1:0]      stk_waddr, stk_raddr, que_waddr, que_raddr, buf_waddr, buf_raddr;
    logic signed [31:0] stk_wdata, que_wdata, buf_wdata;

    logic [CW-1:0] stk_top, sn_down, qn_down, ph_cnt, ph_cnt_m1;

    assign stk_top = stack_count_reg - CW'(1);
    assign sn_down = sn_reg - CW'(1) - CW'(idx_reg);
    assign qn_down = qn_reg - CW'(1) - CW'(idx_reg);

    // pass length: the saved queue fill for both outer passes, the stack fill in the middle
    assign ph_cnt        = (cmd.phase == sqse_pkg::PH_LOAD_QUEUE) ? sn_reg : qn_reg;
    assign ph_cnt_m1     = ph_cnt - CW'(1);
    assign stat.ph_empty = (ph_cnt == '0);
    assign stat.ph_last  = (CW'(idx_reg) == ph_cnt_m1);

    always_comb
    begin
        stack_count_next = stack_count_reg;
        queue_count_next = queue_count_reg;
        queue_head_next  = queue_head_reg;
        queue_tail_next  = queue_tail_reg;
        qn_next          = qn_reg;
        sn_next          = sn_reg;
        idx_next         = idx_reg;
        slot_next        = slot_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        val_next         = val_reg;
        src_next         = src_reg;

        stk_we = 1'b0; stk_re = 1'b0; que_we = 1'b0; que_re = 1'b0; buf_we = 1'b0; buf_re = 1'b0;
        stk_waddr = stack_count_reg[AW-1:0];
        stk_raddr = stk_top[AW-1:0];
        stk_wdata = value_in;
        que_waddr = queue_tail_reg;
        que_raddr = queue_head_reg;
        que_wdata = value_in;
        buf_waddr = idx_reg;
        buf_raddr = qn_down[AW-1:0];
        buf_wdata = queue_rdata_reg;

        if (cmd.issue)
        begin
            done_next   = 1'b1;
            status_next = sqse_pkg::ST_OK;
            val_next    = '0;
            src_next    = sqse_pkg::SRC_REG;
            case (op)
                sqse_pkg::OP_PUSH:
                begin
                    if (stack_count_reg == FULL_CNT)
                        status_next = sqse_pkg::ST_FULL;
                    else
                    begin
                        stk_we           = 1'b1;
                        stack_count_next = stack_count_reg + CW'(1);
                    end
                end
                sqse_pkg::OP_POP:
                begin
                    if (stack_count_reg == '0)
                    begin
                        status_next = sqse_pkg::ST_EMPTY;
                        val_next    = sqse_pkg::EMPTY_WORD;
                    end
                    else
                    begin
                        stk_re           = 1'b1;
                        src_next         = sqse_pkg::SRC_STACK;
                        stack_count_next = stk_top;
                    end
                end
                sqse_pkg::OP_ENQUEUE:
                begin
                    if (queue_count_reg == FULL_CNT)
                        status_next = sqse_pkg::ST_FULL;
                    else
                    begin
                        que_we           = 1'b1;
                        queue_tail_next  = (queue_tail_reg == LAST_SLOT) ? '0
                                         : queue_tail_reg + AW'(1);
                        queue_count_next = queue_count_reg + CW'(1);
                    end
                end
                sqse_pkg::OP_DEQUEUE:
                begin
                    if (queue_count_reg == '0)
                    begin
                        status_next = sqse_pkg::ST_EMPTY;
                        val_next    = sqse_pkg::EMPTY_WORD;
                    end
                    else
                    begin
                        que_re           = 1'b1;
                        src_next         = sqse_pkg::SRC_QUEUE;
                        queue_head_next  = (queue_head_reg == LAST_SLOT) ? '0
                                         : queue_head_reg + AW'(1);
                        queue_count_next = queue_count_reg - CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.swap_init)
        begin
            qn_next   = queue_count_reg;
            sn_next   = stack_count_reg;
            idx_next  = '0;
            slot_next = queue_head_reg;
        end

        if (cmd.sw_rd)
        begin
            unique case (cmd.phase)
                sqse_pkg::PH_SAVE_QUEUE:
                begin
                    que_re    = 1'b1;
                    que_raddr = slot_reg;
                end
                sqse_pkg::PH_LOAD_QUEUE:
                begin
                    stk_re    = 1'b1;
                    stk_raddr = sn_down[AW-1:0];
                end
                default:
                begin
                    buf_re = 1'b1;
                end
            endcase
        end

        if (cmd.sw_wr)
        begin
            idx_next = idx_reg + AW'(1);
            unique case (cmd.phase)
                sqse_pkg::PH_SAVE_QUEUE:
                begin
                    buf_we    = 1'b1;
                    slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + AW'(1);
                end
                sqse_pkg::PH_LOAD_QUEUE:
                begin
                    que_we    = 1'b1;
                    que_waddr = idx_reg;
                    que_wdata = stack_rdata_reg;
                end
                default:
                begin
                    stk_we    = 1'b1;
                    stk_waddr = idx_reg;
                    stk_wdata = buf_rdata_reg;
                end
            endcase
        end

        if (cmd.sw_clr)
            idx_next = '0;

        if (cmd.sw_done)
        begin
            stack_count_next = qn_reg;
            queue_count_next = sn_reg;
            queue_head_next  = '0;
            queue_tail_next  = (sn_reg == FULL_CNT) ? '0 : sn_reg[AW-1:0];
            done_next        = 1'b1;
            status_next      = sqse_pkg::ST_OK;
            val_next         = '0;
            src_next         = sqse_pkg::SRC_REG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg <= '0;
            queue_count_reg <= '0;
            queue_head_reg  <= '0;
            queue_tail_reg  <= '0;
            qn_reg          <= '0;
            sn_reg          <= '0;
            idx_reg         <= '0;
            slot_reg        <= '0;
            done_reg        <= 1'b0;
            src_reg         <= sqse_pkg::SRC_REG;
        end
        else
        begin
            stack_count_reg <= stack_count_next;
            queue_count_reg <= queue_count_next;
            queue_head_reg  <= queue_head_next;
            queue_tail_reg  <= queue_tail_next;
            qn_reg          <= qn_next;
            sn_reg          <= sn_next;
            idx_reg         <= idx_next;
            slot_reg        <= slot_next;
            done_reg        <= done_next;
            src_reg         <= src_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        val_reg    <= val_next;
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[stk_waddr] <= stk_wdata;
        if (stk_re)
            stack_rdata_reg <= stack_mem[stk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (que_we)
            queue_mem[que_waddr] <= que_wdata;
        if (que_re)
            queue_rdata_reg <= queue_mem[que_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[buf_waddr] <= buf_wdata;
        if (buf_re)
            buf_rdata_reg <= buf_mem[buf_raddr];
    end

    assign done   = done_reg;
    assign status = status_reg;

    always_comb
    begin
        case (src_reg)
            sqse_pkg::SRC_STACK: value_out = stack_rdata_reg;
            sqse_pkg::SRC_QUEUE: value_out = queue_rdata_reg;
            default:             value_out = val_reg;
        endcase
    end

endmodule
